// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gbfp_pkg.sv =====
package gbfp_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = CFG_IDX_W'(1);

    localparam logic [15:0] MIN_LEN      = 16'd8;
    localparam logic [15:0] BUF_LEN      = 16'(BUFFER_BYTES);
    localparam logic [15:0] OVERSIZE_LEN = 16'(BUFFER_BYTES + 8);
    localparam logic [15:0] RESP_LIMIT   = 16'(BUFFER_BYTES - 1);
    localparam logic [7:0]  RESP_MARK    = 8'h52;
    localparam logic [7:0]  NEWLINE      = 8'h0A;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    typedef enum logic {
        KIND_PAYLOAD,
        KIND_FRAME_END
    } kind_t;

    typedef enum logic [1:0] {
        ST_GOOD,
        ST_CRC_BAD,
        ST_BAD_LEN,
        ST_OVERSIZE
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        status_t     status;
        logic [15:0] block_id;
        logic [15:0] frame_length;
        logic [15:0] error_total;
    } rec_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/gbfp_front.sv =====
module gbfp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gbfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           in_fire,
    input  logic [7:0]                     in_byte,
    output logic                           rec_valid,
    output gbfp_pkg::rec_t                 rec
);
    import gbfp_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT1, PH_HUNT2, PH_CRC1, PH_CRC2, PH_ID1,
        PH_ID2, PH_LEN1, PH_LEN2, PH_DATA, PH_RESP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] taken_reg, taken_next;
    logic [15:0] err_reg, err_next;
    logic [7:0]  sync1_reg, sync2_reg;

    logic [15:0] crc_seed;
    logic [15:0] crc_new;
    logic [15:0] len_full;
    logic [15:0] plen;
    logic [16:0] taken_inc;
    logic        emit;
    kind_t       kind;
    status_t     status;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;

    assign crc_seed  = (phase_reg == PH_ID1) ? 16'h0000 : crc_reg;
    assign crc_new   = crc_byte(crc_seed, in_byte);
    assign len_full  = {in_byte, len_reg[7:0]};
    assign plen      = len_reg - MIN_LEN;
    assign taken_inc = {1'b0, taken_reg} + 17'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        taken_next  = taken_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        kind        = KIND_FRAME_END;
        status      = ST_GOOD;
        pbyte       = 8'h00;
        pidx        = 8'h00;
        case (phase_reg)
            PH_HUNT2:
            begin
                if (in_byte == sync2_reg)
                    phase_next = PH_CRC1;
                else if (in_byte == RESP_MARK)
                    phase_next = PH_RESP;
                else
                    phase_next = PH_HUNT1;
            end
            PH_CRC1:
            begin
                rx_crc_next = {8'h00, in_byte};
                phase_next  = PH_CRC2;
            end
            PH_CRC2:
            begin
                rx_crc_next = {in_byte, rx_crc_reg[7:0]};
                phase_next  = PH_ID1;
            end
            PH_ID1:
            begin
                id_next    = {8'h00, in_byte};
                crc_next   = crc_new;
                phase_next = PH_ID2;
            end
            PH_ID2:
            begin
                id_next    = {in_byte, id_reg[7:0]};
                crc_next   = crc_new;
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_next   = {8'h00, in_byte};
                crc_next   = crc_new;
                phase_next = PH_LEN2;
            end
            PH_LEN2:
            begin
                len_next   = len_full;
                crc_next   = crc_new;
                phase_next = PH_HUNT1;
                if (len_full < MIN_LEN)
                begin
                    err_next = err_reg + 16'd1;
                    emit     = 1'b1;
                    status   = ST_BAD_LEN;
                end
                else if (len_full[1:0] != 2'b00)
                begin
                    emit   = 1'b1;
                    status = ST_BAD_LEN;
                end
                else if (len_full == MIN_LEN)
                begin
                    emit = 1'b1;
                    if (crc_new != rx_crc_reg)
                    begin
                        err_next = err_reg + 16'd1;
                        status   = ST_CRC_BAD;
                    end
                end
                else
                begin
                    taken_next = 16'h0000;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                crc_next   = crc_new;
                taken_next = taken_inc[15:0];
                pbyte      = in_byte;
                pidx       = taken_reg[7:0];
                if (taken_inc >= {1'b0, plen})
                begin
                    phase_next = PH_HUNT1;
                    emit       = 1'b1;
                    if (len_reg > OVERSIZE_LEN)
                        status = ST_OVERSIZE;
                    else if (crc_new != rx_crc_reg)
                    begin
                        err_next = err_reg + 16'd1;
                        status   = ST_CRC_BAD;
                    end
                end
                else if (taken_reg < BUF_LEN)
                begin
                    emit = 1'b1;
                    kind = KIND_PAYLOAD;
                end
            end
            PH_RESP:
            begin
                if (taken_reg >= RESP_LIMIT)
                    phase_next = PH_HUNT1;
                else
                begin
                    taken_next = taken_inc[15:0];
                    if (in_byte == NEWLINE)
                        phase_next = PH_HUNT1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT1;
                if (in_byte == sync1_reg)
                begin
                    phase_next = PH_HUNT2;
                    taken_next = 16'h0000;
                end
            end
        endcase
    end

    assign rec_valid = in_fire & emit;

    always_comb
    begin
        rec.kind         = kind;
        rec.payload_byte = pbyte;
        rec.byte_index   = pidx;
        rec.status       = status;
        rec.block_id     = id_next;
        rec.frame_length = len_next;
        rec.error_total  = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            crc_reg    <= 16'h0000;
            rx_crc_reg <= 16'h0000;
            id_reg     <= 16'h0000;
            len_reg    <= 16'h0000;
            taken_reg  <= 16'h0000;
            err_reg    <= 16'h0000;
            sync1_reg  <= 8'h24;
            sync2_reg  <= 8'h40;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                crc_reg    <= crc_next;
                rx_crc_reg <= rx_crc_next;
                id_reg     <= id_next;
                len_reg    <= len_next;
                taken_reg  <= taken_next;
                err_reg    <= err_next;
            end
            if (cfg_we && cfg_index == REG_FIRST_SYNC)
                sync1_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_SECOND_SYNC)
                sync2_reg <= cfg_wdata;
        end
    end

endmodule

// ===== rtl/gbfp_queue.sv =====
module gbfp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gbfp_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output gbfp_pkg::rec_t head_rec
);
    import gbfp_pkg::*;

    rec_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign head_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

endmodule

// ===== rtl/gbfp_back.sv =====
module gbfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  gbfp_pkg::rec_t head_rec,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [71:0]    m_tdata,
    output logic           m_tuser
);
    import gbfp_pkg::*;

    logic out_valid_reg;
    rec_t out_rec_reg;

    assign pop      = ~empty & (~out_valid_reg | m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rec_reg.kind;
    assign m_tdata  = {6'b000000,
                       out_rec_reg.error_total,
                       out_rec_reg.frame_length,
                       out_rec_reg.block_id,
                       out_rec_reg.status,
                       out_rec_reg.byte_index,
                       out_rec_reg.payload_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_rec_reg <= head_rec;
    end

endmodule

// ===== rtl/gnss_binary_frame_parser.sv =====
// Binary frame parser for a receiver byte stream. It takes one byte per clock while the
// queue has room: the parser, its CRC-16 update (polynomial 0x1021, zero seed) and the
// record it raises all settle in the cycle the byte is accepted, and the record then
// passes through a four-word queue into the output register before it appears on the
// master side. s_tready falls only when the queue is full, which takes a stalled
// master side. Sync bytes may be rewritten through the cfg port while idle.
module gnss_binary_frame_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gbfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // payload_byte, byte_index, status, block_id, frame_length, error_total, zero pad
    output logic [71:0]                    m_tdata,
    output logic                           m_tuser   // kind
);
    import gbfp_pkg::*;

    logic rec_valid;
    rec_t rec;
    logic full;
    logic empty;
    logic pop;
    rec_t head_rec;
    logic in_fire;

    assign s_tready = ~full;
    assign in_fire  = s_tvalid & ~full;

    gbfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    gbfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_valid),
        .push_rec (rec),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_rec (head_rec)
    );

    gbfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_rec (head_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/gbfp_checker.sv =====
`include "assert_macros.svh"

module gbfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `ASSERT_IMPL(a_back_full, !s_tready, m_tvalid, "input held off with nothing to deliver")
    `ASSERT_IMPL(a_payload_status, m_tvalid && !m_tuser, m_tdata[17:16] == 2'b00, "payload word with status")

endmodule

bind gnss_binary_frame_parser gbfp_checker u_chk (.*);
